[src/cwmm_pkg.sv]
package cwmm_pkg;

    // Default sizing
    localparam int DEF_MAX_WINDOW  = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int MODE_BITS      = 2;
    localparam int WSIZE_BITS     = 6;
    localparam int THRESH_BITS    = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FILTER_MODE    = 2'd0,
        CFG_WINDOW_SIZE    = 2'd1,
        CFG_MASK_THRESHOLD = 2'd2
    } cfg_index_t;

    // Filter modes; the unused code runs as mean
    localparam logic [MODE_BITS-1:0] MODE_MIN  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MAX  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_MEAN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_PICK,
        ST_DIV,
        ST_OUT
    } state_t;

    // Control shared by every cell of the row
    typedef struct packed {
        logic                 shift;
        logic [MODE_BITS-1:0] mode;
    } cell_ctrl_t;

endpackage

[src/cwmm_if.sv]
// Sample channel
interface cwmm_in_if #(parameter int SAMPLE_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   final_sample;

    modport source (output valid, sample, final_sample, input ready);
    modport sink   (input valid, sample, final_sample, output ready);
endinterface

// Result channel
interface cwmm_out_if #(parameter int SAMPLE_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] filtered_value;
    logic                   below_threshold;
    logic                   final_output;

    modport source (output valid, filtered_value, below_threshold, final_output, input ready);
    modport sink   (input valid, filtered_value, below_threshold, final_output, output ready);
endinterface

[src/centered_window_min_max_mean.sv]
// Centered sliding-window min / max / mean over a stream of unsigned Q4.12
// samples. Samples shift through a row of MAX_WINDOW cells; each cell keeps a
// registered running min, max or sum of itself and all newer samples, so every
// clipped window is read off one cell. A sample that releases no result is
// taken while the block stays idle. A sample that releases results first lets
// the row settle. Each result it releases (one, or up to delay+1 on the
// final sample) is then picked from the row in min/max mode, or picked and
// passed through a bit-serial divide in mean mode. After that the result
// stays on the output until the sink takes it. One sample is in work at a time.
// Configuration is written through cfg_write_en / cfg_index / cfg_data.
module centered_window_min_max_mean
    import cwmm_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    cwmm_in_if.sink                   in_ch,
    cwmm_out_if.source                out_ch
);

    localparam int IDX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
    localparam int CW       = CNT_BITS + 1;
    localparam int SUM_BITS = SAMPLE_BITS + IDX_BITS;

    // Configuration registers
    logic [MODE_BITS-1:0]   mode_reg;
    logic [WSIZE_BITS-1:0]  wsize_reg;
    logic [THRESH_BITS-1:0] thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MIN;
            wsize_reg  <= WSIZE_BITS'(1);
            thresh_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_FILTER_MODE:    mode_reg   <= cfg_data[MODE_BITS-1:0];
                CFG_WINDOW_SIZE:    wsize_reg  <= cfg_data[WSIZE_BITS-1:0];
                CFG_MASK_THRESHOLD: thresh_reg <= cfg_data[THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Control registers
    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    seen_reg, seen_next;
    logic [CNT_BITS-1:0]    k_reg, k_next;
    logic [CW-1:0]          m_reg, m_next;
    logic [CW-1:0]          half_reg, half_next;
    logic                   fin_reg, fin_next;
    logic [CNT_BITS-1:0]    settle_reg, settle_next;
    logic [SAMPLE_BITS-1:0] value_reg, value_next;

    logic                   accept;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_BITS-1:0]    quotient;
    logic [CW-1:0]          ws;
    logic [CW-1:0]          ws_half;
    logic [CW-1:0]          delay;
    logic [CW-1:0]          k_ext;
    logic [CW-1:0]          reach;
    logic [CW-1:0]          pick_idx;
    logic [CW-1:0]          span;
    logic [SUM_BITS-1:0]    pick_acc;
    cell_ctrl_t             ctrl;

    // Row of cells; index 0 holds the newest sample
    logic [SAMPLE_BITS-1:0] smp_w [0:MAX_WINDOW];
    logic [SUM_BITS-1:0]    acc_w [0:MAX_WINDOW];

    assign ctrl.shift = accept;
    assign ctrl.mode  = mode_reg;
    assign smp_w[0]   = in_ch.sample;
    assign acc_w[0]   = (mode_reg == MODE_MIN) ? SUM_BITS'({SAMPLE_BITS{1'b1}}) : '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            cwmm_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .SUM_BITS   (SUM_BITS)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .sample_in (smp_w[gi]),
                .acc_in    (acc_w[gi]),
                .sample_out(smp_w[gi+1]),
                .acc_out   (acc_w[gi+1])
            );
        end
    endgenerate

    cwmm_div #(
        .NUM_BITS(SUM_BITS),
        .DEN_BITS(CW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(pick_acc),
        .divisor (span),
        .done    (div_done),
        .quotient(quotient)
    );

    // Effective window size, clamped to 1..MAX_WINDOW
    always_comb
    begin
        if (wsize_reg == '0)
        begin
            ws = CW'(1);
        end
        else if (int'(wsize_reg) > MAX_WINDOW)
        begin
            ws = CW'(MAX_WINDOW);
        end
        else
        begin
            ws = CW'(wsize_reg);
        end
    end

    assign ws_half  = ws >> 1;
    assign delay    = ws - ws_half - CW'(1);
    assign k_ext    = CW'(k_reg);
    assign reach    = m_reg + half_reg;
    assign pick_idx = (k_ext < reach) ? k_ext : reach;
    assign span     = pick_idx + CW'(1);
    assign pick_acc = acc_w[1 + int'(pick_idx[IDX_BITS-1:0])];

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seen_reg   <= '0;
            k_reg      <= '0;
            m_reg      <= '0;
            half_reg   <= '0;
            fin_reg    <= 1'b0;
            settle_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            seen_reg   <= seen_next;
            k_reg      <= k_next;
            m_reg      <= m_next;
            half_reg   <= half_next;
            fin_reg    <= fin_next;
            settle_reg <= settle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        seen_next   = seen_reg;
        k_next      = k_reg;
        m_next      = m_reg;
        half_next   = half_reg;
        fin_next    = fin_reg;
        settle_next = settle_reg;
        value_next  = value_reg;
        div_start   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    k_next      = seen_reg;
                    half_next   = ws_half;
                    fin_next    = in_ch.final_sample;
                    settle_next = '0;
                    if (in_ch.final_sample)
                    begin
                        seen_next  = '0;
                        m_next     = (CW'(seen_reg) < delay) ? CW'(seen_reg) : delay;
                        state_next = ST_SETTLE;
                    end
                    else
                    begin
                        if (int'(seen_reg) < MAX_WINDOW)
                        begin
                            seen_next = seen_reg + CNT_BITS'(1);
                        end
                        m_next = delay;
                        if (CW'(seen_reg) >= delay)
                        begin
                            state_next = ST_SETTLE;
                        end
                    end
                end
            end
            ST_SETTLE:
            begin
                settle_next = settle_reg + CNT_BITS'(1);
                if (int'(settle_reg) == MAX_WINDOW - 1)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (mode_reg == MODE_MIN || mode_reg == MODE_MAX)
                begin
                    value_next = pick_acc[SAMPLE_BITS-1:0];
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    value_next = quotient[SAMPLE_BITS-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    if (fin_reg && m_reg != '0)
                    begin
                        m_next     = m_reg - CW'(1);
                        state_next = ST_PICK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result channel
    assign out_ch.valid           = (state_reg == ST_OUT);
    assign out_ch.filtered_value  = value_reg;
    assign out_ch.below_threshold = (32'(value_reg) < 32'(thresh_reg));
    assign out_ch.final_output    = fin_reg && (m_reg == '0);

endmodule

[src/cwmm_cell.sv]
// One window position: holds a sample and the running min/max/sum up to itself
module cwmm_cell
    import cwmm_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int SUM_BITS    = DEF_SAMPLE_BITS + 5
)
(
    input  logic                   clk,
    input  cell_ctrl_t             ctrl,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  logic [SUM_BITS-1:0]    acc_in,
    output logic [SAMPLE_BITS-1:0] sample_out,
    output logic [SUM_BITS-1:0]    acc_out
);

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SUM_BITS-1:0]    acc_reg;
    logic [SUM_BITS-1:0]    acc_next;
    logic [SUM_BITS-1:0]    sample_ext;

    assign sample_ext = SUM_BITS'(sample_reg);

    // Combine the neighbor's partial result with this sample
    always_comb
    begin
        priority if (ctrl.mode == MODE_MIN)
        begin
            acc_next = (sample_ext < acc_in) ? sample_ext : acc_in;
        end
        else if (ctrl.mode == MODE_MAX)
        begin
            acc_next = (sample_ext > acc_in) ? sample_ext : acc_in;
        end
        else
        begin
            acc_next = acc_in + sample_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            sample_reg <= sample_in;
        end
        acc_reg <= acc_next;
    end

    assign sample_out = sample_reg;
    assign acc_out    = acc_reg;

endmodule

[src/cwmm_div.sv]
// Restoring divider, one quotient bit per cycle
module cwmm_div
    import cwmm_pkg::*;
#(
    parameter int NUM_BITS = 21,
    parameter int DEN_BITS = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0] divisor,
    output logic                done,
    output logic [NUM_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic [CNT_W-1:0]    cnt_reg;
    logic                done_reg;
    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [DEN_BITS:0]   trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[NUM_BITS-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(NUM_BITS);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
            rem_reg <= fits ? DEN_BITS'(trial - {1'b0, den_reg}) : trial[DEN_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/cwmm_checker.sv]
// Port-level checks for the window filter
module cwmm_checker
    import cwmm_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   in_final,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_value,
    input logic                   out_final
);

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("stalled result changed");

    // No sample is taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // The last result of a stream ends the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_final |=> !out_valid)
        else $error("result after final transfer");

    // A result never shows in the cycle right after a sample transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result without settle time");

    // Taking a final sample drops input ready
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_final |=> !in_ready)
        else $error("final sample produced no results");

endmodule

bind centered_window_min_max_mean cwmm_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_cwmm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_final (in_ch.final_sample),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_value(out_ch.filtered_value),
    .out_final(out_ch.final_output)
);
